>>> src/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg: shared definitions for the priority stream preemption arbiter
// Stream table sizes, command codes, microcode word layout and control store.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

  localparam int NUM_STREAMS       = 4;
  localparam int NUM_EFFECTS       = 128;
  localparam int SILENCE_CODE      = 0;
  localparam int MUSIC_CODE        = 1;
  localparam int MUSIC_STREAM      = 2;
  localparam int BACKGROUND_STREAM = 0;
  localparam int BG_RESET_VOLUME   = 8;
  localparam int MAX_TRACKS        = 1000;

  // Table index width; a request index is always 4 bits wide
  localparam int SIW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam bit MUSIC_OOR = (MUSIC_STREAM >= NUM_STREAMS);

  localparam int DIV_W   = 32;
  localparam int DIV_CW  = $clog2(DIV_W);
  localparam int TRK_W   = 10;

  // Request opcodes
  localparam logic [2:0] OP_EFFECT = 3'd0;
  localparam logic [2:0] OP_VOLUME = 3'd1;
  localparam logic [2:0] OP_MUSIC  = 3'd2;
  localparam logic [2:0] OP_FINISH = 3'd3;
  localparam logic [2:0] OP_RETRY  = 3'd4;

  // Command codes
  localparam logic [1:0] ACT_STOP   = 2'd0;
  localparam logic [1:0] ACT_EFFECT = 2'd1;
  localparam logic [1:0] ACT_TRACK  = 2'd2;
  localparam logic [1:0] ACT_VOLUME = 2'd3;

  localparam int STEP_W = 5;

  typedef enum logic [4:0] {
    U_NOP,
    U_LATCH,
    U_WR_VL,
    U_WR_PEND,
    U_WR_VOL,
    U_EMIT_VOL,
    U_DIV_TIME,
    U_SEED,
    U_DIV_STEP,
    U_SET_OFF,
    U_WR_MUSIC,
    U_SET_ACT,
    U_LOAD_LOOP,
    U_DEC_PTR,
    U_CLR_PEND,
    U_EMIT_STOP,
    U_EMIT_PLAY
  } uop_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_IDLE,
    C_OPJMP,
    C_IDX_BAD,
    C_NOSKIP,
    C_PREEMPT,
    C_SIL_ACT,
    C_NOT_ACT,
    C_SEEDED,
    C_DIV_BUSY,
    C_MUSIC_OOR,
    C_WALK_STOP,
    C_PEND_SIL,
    C_PEND_BAD
  } cond_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic       idx_bad;
    logic       no_skip;
    logic       preempt;
    logic       sil_act;
    logic       not_act;
    logic       seeded;
    logic       div_busy;
    logic       walk_stop;
    logic       pend_sil;
    logic       pend_bad;
    logic [2:0] op;
  } dp_status_t;

  // Program entry points
  localparam logic [STEP_W-1:0] S_IDLE    = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP    = 5'd1;
  localparam logic [STEP_W-1:0] S_EFFECT  = 5'd2;
  localparam logic [STEP_W-1:0] S_SKIP    = 5'd5;
  localparam logic [STEP_W-1:0] S_PREEMPT = 5'd8;
  localparam logic [STEP_W-1:0] S_VOLUME  = 5'd9;
  localparam logic [STEP_W-1:0] S_MUSIC   = 5'd12;
  localparam logic [STEP_W-1:0] S_STEPOFF = 5'd16;
  localparam logic [STEP_W-1:0] S_ADVANCE = 5'd21;
  localparam logic [STEP_W-1:0] S_WALK    = 5'd22;
  localparam logic [STEP_W-1:0] S_WALKEND = 5'd24;
  localparam logic [STEP_W-1:0] S_PLAY    = 5'd25;
  localparam logic [STEP_W-1:0] S_BADEFF  = 5'd28;
  localparam logic [STEP_W-1:0] S_STOP    = 5'd29;

  function automatic ucw_t mk(uop_t u, cond_t c, logic [STEP_W-1:0] t);
    ucw_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Control store jumps to target (or op entry) if taken, else falls through
  function automatic ucw_t ucode(logic [STEP_W-1:0] addr);
    ucw_t w;
    case (addr)
      5'd0:    w = mk(U_LATCH,     C_IDLE,      S_IDLE);
      5'd1:    w = mk(U_NOP,       C_OPJMP,     S_IDLE);
      // effect request
      5'd2:    w = mk(U_NOP,       C_IDX_BAD,   S_IDLE);
      5'd3:    w = mk(U_WR_VL,     C_NOSKIP,    S_IDLE);
      5'd4:    w = mk(U_WR_PEND,   C_NEXT,      S_IDLE);
      // skip handling on the pointed stream
      5'd5:    w = mk(U_NOP,       C_PREEMPT,   S_PREEMPT);
      5'd6:    w = mk(U_NOP,       C_SIL_ACT,   S_ADVANCE);
      5'd7:    w = mk(U_NOP,       C_ALWAYS,    S_IDLE);
      5'd8:    w = mk(U_SET_ACT,   C_ALWAYS,    S_PLAY);
      // volume set
      5'd9:    w = mk(U_NOP,       C_IDX_BAD,   S_IDLE);
      5'd10:   w = mk(U_WR_VOL,    C_NOT_ACT,   S_IDLE);
      5'd11:   w = mk(U_EMIT_VOL,  C_ALWAYS,    S_IDLE);
      // music step
      5'd12:   w = mk(U_NOP,       C_SEEDED,    S_STEPOFF);
      5'd13:   w = mk(U_DIV_TIME,  C_NEXT,      S_IDLE);
      5'd14:   w = mk(U_NOP,       C_DIV_BUSY,  5'd14);
      5'd15:   w = mk(U_SEED,      C_NEXT,      S_IDLE);
      5'd16:   w = mk(U_DIV_STEP,  C_NEXT,      S_IDLE);
      5'd17:   w = mk(U_NOP,       C_DIV_BUSY,  5'd17);
      5'd18:   w = mk(U_SET_OFF,   C_NEXT,      S_IDLE);
      5'd19:   w = mk(U_NOP,       C_MUSIC_OOR, S_IDLE);
      5'd20:   w = mk(U_WR_MUSIC,  C_ALWAYS,    S_SKIP);
      // advance: reload loop effect, walk down to a non-silent stream
      5'd21:   w = mk(U_LOAD_LOOP, C_NEXT,      S_IDLE);
      5'd22:   w = mk(U_NOP,       C_WALK_STOP, S_WALKEND);
      5'd23:   w = mk(U_DEC_PTR,   C_ALWAYS,    S_WALK);
      5'd24:   w = mk(U_SET_ACT,   C_NEXT,      S_IDLE);
      // start a play on the active stream
      5'd25:   w = mk(U_NOP,       C_PEND_SIL,  S_STOP);
      5'd26:   w = mk(U_NOP,       C_PEND_BAD,  S_BADEFF);
      5'd27:   w = mk(U_EMIT_PLAY, C_ALWAYS,    S_IDLE);
      5'd28:   w = mk(U_CLR_PEND,  C_NEXT,      S_IDLE);
      5'd29:   w = mk(U_EMIT_STOP, C_ALWAYS,    S_IDLE);
      default: w = mk(U_NOP,       C_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] op_entry(logic [2:0] op);
    logic [STEP_W-1:0] e;
    case (op)
      OP_EFFECT: e = S_EFFECT;
      OP_VOLUME: e = S_VOLUME;
      OP_MUSIC:  e = S_MUSIC;
      OP_FINISH: e = S_ADVANCE;
      OP_RETRY:  e = S_PLAY;
      default:   e = S_IDLE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

>>> src/priority_stream_preemption_arbiter.sv
// ----------------------------------------------------------------------------
// priority_stream_preemption_arbiter: sound stream arbiter with preemption
// Microcoded control over a small stream table; emits stop, play-effect,
// play-track and set-volume commands.
//
// Channel   Signals                                   Handshake
// request   opcode..time_tenths                       start & !busy
// command   action, active_index, effect_code,        result_valid, one cycle
//           track_index, out_volume
// config    cfg_data (track_count)                    cfg_valid & cfg_ready
//
// A request holds busy while its program runs, longer for each stream the walk
// steps down (at most three). A music step adds one remainder pass once seeded,
// and two on the first one. The remainder unit and the walk loop set the length.
// The command appears in the cycle after its last step, with busy already low.
// Reset is synchronous and restores the stream table and offset state.
// The command receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_stream_preemption_arbiter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  opcode,
  input  wire logic [3:0]                  stream_index,
  input  wire logic                        skip_flag,
  input  wire logic [7:0]                  skip_effect,
  input  wire logic [7:0]                  loop_effect,
  input  wire logic [7:0]                  volume,
  input  wire logic signed [1:0]           track_step,
  input  wire logic [31:0]                 time_tenths,
  output logic                             result_valid,
  output logic [1:0]                       action,
  output logic [3:0]                       active_index,
  output logic [7:0]                       effect_code,
  output logic [prm_pkg::TRK_W-1:0]        track_index,
  output logic [7:0]                       out_volume,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [prm_pkg::TRK_W-1:0]   cfg_data
);

  prm_pkg::ucw_t       ucw;
  prm_pkg::dp_status_t status;

  assign cfg_ready = !busy;

  prm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ucw    (ucw),
    .busy   (busy)
  );

  prm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ucw          (ucw),
    .start        (start),
    .opcode       (opcode),
    .stream_index (stream_index),
    .skip_flag    (skip_flag),
    .skip_effect  (skip_effect),
    .loop_effect  (loop_effect),
    .volume       (volume),
    .track_step   (track_step),
    .time_tenths  (time_tenths),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .action       (action),
    .active_index (active_index),
    .effect_code  (effect_code),
    .track_index  (track_index),
    .out_volume   (out_volume)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("command issued while a transaction is still running");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  a_active_in_table: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, active_index} < 5'(prm_pkg::NUM_STREAMS)))
    else $error("active stream outside the stream table");

  a_effect_not_silent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && action == prm_pkg::ACT_EFFECT)
      |-> (effect_code != 8'(prm_pkg::SILENCE_CODE)
           && effect_code < 8'(prm_pkg::NUM_EFFECTS)))
    else $error("play command carries a silent or invalid effect");

endmodule

`default_nettype wire

>>> src/prm_div.sv
// ----------------------------------------------------------------------------
// prm_div: radix-2 restoring remainder unit
// One quotient bit per cycle; remainder is valid once busy falls.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [prm_pkg::DIV_W-1:0]    dividend,
  input  wire logic [prm_pkg::TRK_W-1:0]    divisor,
  output logic                              busy,
  output logic [prm_pkg::TRK_W-1:0]         remainder
);

  logic [prm_pkg::DIV_CW-1:0] cnt;
  logic [prm_pkg::DIV_W-1:0]  shreg;
  logic [prm_pkg::TRK_W:0]    trial;
  logic                       fits;

  assign trial = {remainder, shreg[prm_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      cnt       <= prm_pkg::DIV_CW'(prm_pkg::DIV_W - 1);
      shreg     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shreg <= {shreg[prm_pkg::DIV_W-2:0], 1'b0};
      if (fits) begin
        remainder <= prm_pkg::TRK_W'(trial - {1'b0, divisor});
      end else begin
        remainder <= trial[prm_pkg::TRK_W-1:0];
      end
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/prm_seq.sv
// ----------------------------------------------------------------------------
// prm_seq: microprogram sequencer
// Step counter over the control store with conditional and dispatch jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire prm_pkg::dp_status_t  status,
  output prm_pkg::ucw_t             ucw,
  output logic                      busy
);

  logic [prm_pkg::STEP_W-1:0] step;
  logic [prm_pkg::STEP_W-1:0] step_next;
  logic                       take;

  assign ucw  = prm_pkg::ucode(step);
  assign busy = step != prm_pkg::S_IDLE;

  always_comb begin
    unique case (ucw.cond)
      prm_pkg::C_NEXT:      take = 1'b0;
      prm_pkg::C_ALWAYS:    take = 1'b1;
      prm_pkg::C_IDLE:      take = !start;
      prm_pkg::C_OPJMP:     take = 1'b1;
      prm_pkg::C_IDX_BAD:   take = status.idx_bad;
      prm_pkg::C_NOSKIP:    take = status.no_skip;
      prm_pkg::C_PREEMPT:   take = status.preempt;
      prm_pkg::C_SIL_ACT:   take = status.sil_act;
      prm_pkg::C_NOT_ACT:   take = status.not_act;
      prm_pkg::C_SEEDED:    take = status.seeded;
      prm_pkg::C_DIV_BUSY:  take = status.div_busy;
      prm_pkg::C_MUSIC_OOR: take = prm_pkg::MUSIC_OOR;
      prm_pkg::C_WALK_STOP: take = status.walk_stop;
      prm_pkg::C_PEND_SIL:  take = status.pend_sil;
      prm_pkg::C_PEND_BAD:  take = status.pend_bad;
      default:              take = 1'b1;
    endcase

    if (ucw.cond == prm_pkg::C_OPJMP) begin
      step_next = prm_pkg::op_entry(status.op);
    end else if (take) begin
      step_next = ucw.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= prm_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

>>> src/prm_dp.sv
// ----------------------------------------------------------------------------
// prm_dp: stream table datapath
// Stream table, active stream, track offset, remainder unit and command
// register, all driven by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire prm_pkg::ucw_t               ucw,
  input  wire logic                        start,
  input  wire logic [2:0]                  opcode,
  input  wire logic [3:0]                  stream_index,
  input  wire logic                        skip_flag,
  input  wire logic [7:0]                  skip_effect,
  input  wire logic [7:0]                  loop_effect,
  input  wire logic [7:0]                  volume,
  input  wire logic signed [1:0]           track_step,
  input  wire logic [31:0]                 time_tenths,
  input  wire logic                        cfg_we,
  input  wire logic [prm_pkg::TRK_W-1:0]   cfg_data,
  output prm_pkg::dp_status_t              status,
  output logic                             result_valid,
  output logic [1:0]                       action,
  output logic [3:0]                       active_index,
  output logic [7:0]                       effect_code,
  output logic [prm_pkg::TRK_W-1:0]        track_index,
  output logic [7:0]                       out_volume
);

  logic [7:0] pend [prm_pkg::NUM_STREAMS];
  logic [7:0] loopf [prm_pkg::NUM_STREAMS];
  logic [7:0] vol [prm_pkg::NUM_STREAMS];

  logic [3:0]                act;
  logic [3:0]                ptr;
  logic [prm_pkg::TRK_W-1:0] offset;
  logic                      seeded;
  logic [prm_pkg::TRK_W-1:0] track_count;

  logic [2:0]        op_q;
  logic              skip_q;
  logic [7:0]        skip_eff_q;
  logic [7:0]        loop_q;
  logic [7:0]        vol_q;
  logic signed [1:0] step_q;
  logic [31:0]       time_q;

  logic [prm_pkg::SIW-1:0]   pidx;
  logic [7:0]                pend_cur;
  logic [prm_pkg::TRK_W-1:0] n_eff;
  logic [11:0]               step_sum;
  logic                      div_start;
  logic [prm_pkg::DIV_W-1:0] div_dividend;
  logic                      div_busy;
  logic [prm_pkg::TRK_W-1:0] div_rem;
  logic                      is_sil;

  assign pidx     = ptr[prm_pkg::SIW-1:0];
  assign pend_cur = pend[pidx];
  assign is_sil   = pend_cur == 8'(prm_pkg::SILENCE_CODE);

  always_comb begin
    priority if (track_count == '0) begin
      n_eff = prm_pkg::TRK_W'(1);
    end else if (track_count > prm_pkg::TRK_W'(prm_pkg::MAX_TRACKS)) begin
      n_eff = prm_pkg::TRK_W'(prm_pkg::MAX_TRACKS);
    end else begin
      n_eff = track_count;
    end
  end

  // offset + 2n + step stays non-negative and fits in 12 bits
  assign step_sum = {2'b00, offset} + {1'b0, n_eff, 1'b0} + {{10{step_q[1]}}, step_q};

  assign div_start    = (ucw.uop == prm_pkg::U_DIV_TIME) || (ucw.uop == prm_pkg::U_DIV_STEP);
  assign div_dividend = (ucw.uop == prm_pkg::U_DIV_TIME) ? time_q
                                                         : {20'd0, step_sum};

  prm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (n_eff),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  always_comb begin
    status.idx_bad   = {1'b0, ptr} >= 5'(prm_pkg::NUM_STREAMS);
    status.no_skip   = !skip_q;
    status.preempt   = !is_sil && (ptr >= act);
    status.sil_act   = is_sil && (ptr == act);
    status.not_act   = ptr != act;
    status.seeded    = seeded;
    status.div_busy  = div_busy;
    status.walk_stop = !is_sil || (ptr == '0);
    status.pend_sil  = is_sil;
    status.pend_bad  = pend_cur >= 8'(prm_pkg::NUM_EFFECTS);
    status.op        = op_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < prm_pkg::NUM_STREAMS; i++) begin
        pend[i]  <= 8'(prm_pkg::SILENCE_CODE);
        loopf[i] <= 8'(prm_pkg::SILENCE_CODE);
        vol[i]   <= (i == prm_pkg::BACKGROUND_STREAM) ? 8'(prm_pkg::BG_RESET_VOLUME) : 8'd0;
      end
      act          <= '0;
      ptr          <= '0;
      offset       <= '0;
      seeded       <= 1'b0;
      track_count  <= prm_pkg::TRK_W'(1);
      op_q         <= prm_pkg::OP_EFFECT;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ucw.uop == prm_pkg::U_EMIT_VOL) || (ucw.uop == prm_pkg::U_EMIT_STOP)
                      || (ucw.uop == prm_pkg::U_EMIT_PLAY);
      if (cfg_we) begin
        track_count <= cfg_data;
      end
      unique case (ucw.uop)
        prm_pkg::U_NOP: begin
        end
        prm_pkg::U_LATCH: begin
          if (start) begin
            op_q       <= opcode;
            skip_q     <= skip_flag;
            skip_eff_q <= skip_effect;
            loop_q     <= loop_effect;
            vol_q      <= volume;
            step_q     <= track_step;
            time_q     <= time_tenths;
            priority if (opcode == prm_pkg::OP_MUSIC) begin
              ptr <= 4'(prm_pkg::MUSIC_STREAM);
            end else if (opcode == prm_pkg::OP_FINISH || opcode == prm_pkg::OP_RETRY) begin
              ptr <= act;
            end else begin
              ptr <= stream_index;
            end
          end
        end
        prm_pkg::U_WR_VL: begin
          vol[pidx]   <= vol_q;
          loopf[pidx] <= loop_q;
        end
        prm_pkg::U_WR_PEND: begin
          pend[pidx] <= skip_eff_q;
        end
        prm_pkg::U_WR_VOL: begin
          vol[pidx] <= vol_q;
        end
        prm_pkg::U_EMIT_VOL: begin
          action       <= prm_pkg::ACT_VOLUME;
          active_index <= act;
          effect_code  <= '0;
          track_index  <= '0;
          out_volume   <= vol_q;
        end
        prm_pkg::U_DIV_TIME: begin
        end
        prm_pkg::U_SEED: begin
          offset <= div_rem;
          seeded <= 1'b1;
        end
        prm_pkg::U_DIV_STEP: begin
        end
        prm_pkg::U_SET_OFF: begin
          offset <= div_rem;
        end
        prm_pkg::U_WR_MUSIC: begin
          vol[pidx]  <= vol_q;
          pend[pidx] <= 8'(prm_pkg::MUSIC_CODE);
        end
        prm_pkg::U_SET_ACT: begin
          act <= ptr;
        end
        prm_pkg::U_LOAD_LOOP: begin
          pend[pidx] <= loopf[pidx];
        end
        prm_pkg::U_DEC_PTR: begin
          ptr <= ptr - 1'b1;
        end
        prm_pkg::U_CLR_PEND: begin
          pend[pidx] <= 8'(prm_pkg::SILENCE_CODE);
        end
        prm_pkg::U_EMIT_STOP: begin
          action       <= prm_pkg::ACT_STOP;
          active_index <= act;
          effect_code  <= '0;
          track_index  <= '0;
          out_volume   <= '0;
        end
        prm_pkg::U_EMIT_PLAY: begin
          active_index <= act;
          out_volume   <= vol[pidx];
          if (act == 4'(prm_pkg::MUSIC_STREAM)) begin
            action      <= prm_pkg::ACT_TRACK;
            effect_code <= '0;
            track_index <= offset;
          end else begin
            action      <= prm_pkg::ACT_EFFECT;
            effect_code <= pend_cur;
            track_index <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for priority_stream_preemption_arbiter
// A queue-fed driver issues requests with random gaps, or back to back in one
// phase. A scoreboard mirror of the stream table predicts every command, and a
// monitor compares each strobed command against the oldest prediction. The
// track count is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import prm_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          REST_CYCLES  = 100;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          RUN_LIMIT    = 600000 * 2 * HALF_PERIOD;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 50;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam logic [1:0]  STEP_HOLD    = 2'b00;
  localparam logic [1:0]  STEP_FWD     = 2'b01;
  localparam logic [1:0]  STEP_BACK2   = 2'b10;
  localparam logic [1:0]  STEP_BACK    = 2'b11;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  stream_index;
    logic        skip_flag;
    logic [7:0]  skip_effect;
    logic [7:0]  loop_effect;
    logic [7:0]  volume;
    logic [1:0]  track_step;
    logic [31:0] time_tenths;
  } snd_req_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [3:0]       active_index;
    logic [7:0]       effect_code;
    logic [TRK_W-1:0] track_index;
    logic [7:0]       out_volume;
  } snd_cmd_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic [2:0]        opcode       = '0;
  logic [3:0]        stream_index = '0;
  logic              skip_flag    = 1'b0;
  logic [7:0]        skip_effect  = '0;
  logic [7:0]        loop_effect  = '0;
  logic [7:0]        volume       = '0;
  logic [1:0]        track_step   = '0;
  logic [31:0]       time_tenths  = '0;
  logic              cfg_valid    = 1'b0;
  logic [TRK_W-1:0]  cfg_data     = '0;
  logic              busy;
  logic              result_valid;
  logic [1:0]        action;
  logic [3:0]        active_index;
  logic [7:0]        effect_code;
  logic [TRK_W-1:0]  track_index;
  logic [7:0]        out_volume;
  logic              cfg_ready;

  // Mirror of the stream table and music offset
  logic [7:0]        m_pending [NUM_STREAMS];
  logic [7:0]        m_loop    [NUM_STREAMS];
  logic [7:0]        m_vol     [NUM_STREAMS];
  logic [SIW-1:0]    m_active;
  int unsigned       m_offset;
  bit                m_seeded;
  logic [TRK_W-1:0]  m_track_count;

  snd_req_t          pending_reqs [$];
  snd_cmd_t          expected_cmds [$];
  snd_req_t          cur_req;
  int                n_pushed   = 0;
  int                n_accepted = 0;
  int                n_mismatch = 0;
  bit                no_gaps    = 1'b0;

  priority_stream_preemption_arbiter i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .stream_index (stream_index),
    .skip_flag    (skip_flag),
    .skip_effect  (skip_effect),
    .loop_effect  (loop_effect),
    .volume       (volume),
    .track_step   (track_step),
    .time_tenths  (time_tenths),
    .result_valid (result_valid),
    .action       (action),
    .active_index (active_index),
    .effect_code  (effect_code),
    .track_index  (track_index),
    .out_volume   (out_volume),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_mismatch++;
  endtask

  function automatic snd_cmd_t make_cmd(logic [1:0] act, logic [7:0] code,
                                        logic [TRK_W-1:0] trk, logic [7:0] vol);
    snd_cmd_t c;
    c.action       = act;
    c.active_index = 4'(m_active);
    c.effect_code  = code;
    c.track_index  = trk;
    c.out_volume   = vol;
    return c;
  endfunction

  function automatic snd_cmd_t play_active();
    logic [SIW-1:0] a;
    logic [7:0]     code;
    a    = m_active;
    code = m_pending[a];
    if (code == 8'(SILENCE_CODE))
      return make_cmd(ACT_STOP, '0, '0, '0);
    // drop an out-of-range effect code
    if (code >= 8'(NUM_EFFECTS)) begin
      m_pending[a] = 8'(SILENCE_CODE);
      return make_cmd(ACT_STOP, '0, '0, '0);
    end
    if (int'(a) == MUSIC_STREAM)
      return make_cmd(ACT_TRACK, '0, m_offset[TRK_W-1:0], m_vol[a]);
    return make_cmd(ACT_EFFECT, code, '0, m_vol[a]);
  endfunction

  function automatic snd_cmd_t finish_and_walk();
    logic [SIW-1:0] a;
    a            = m_active;
    m_pending[a] = m_loop[a];
    while (m_pending[a] == 8'(SILENCE_CODE) && a != '0)
      a--;
    m_active = a;
    return play_active();
  endfunction

  function automatic bit try_preempt(logic [SIW-1:0] idx, output snd_cmd_t c);
    bit silent;
    silent = (m_pending[idx] == 8'(SILENCE_CODE));
    if (!silent && idx >= m_active) begin
      m_active = idx;
      c = play_active();
      return 1'b1;
    end
    if (silent && idx == m_active) begin
      c = finish_and_walk();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_cmd(snd_req_t r);
    snd_cmd_t       c;
    int unsigned    n;
    logic [SIW-1:0] si;
    si = r.stream_index[SIW-1:0];
    case (r.opcode)
      OP_EFFECT: begin
        if ({1'b0, r.stream_index} < 5'(NUM_STREAMS)) begin
          m_vol[si]  = r.volume;
          m_loop[si] = r.loop_effect;
          if (r.skip_flag) begin
            m_pending[si] = r.skip_effect;
            if (try_preempt(si, c))
              expected_cmds.push_back(c);
          end
        end
      end
      OP_VOLUME: begin
        if ({1'b0, r.stream_index} < 5'(NUM_STREAMS)) begin
          m_vol[si] = r.volume;
          if (m_active == si)
            expected_cmds.push_back(make_cmd(ACT_VOLUME, '0, '0, r.volume));
        end
      end
      OP_MUSIC: begin
        if (m_track_count == '0)
          n = 1;
        else if (m_track_count > TRK_W'(MAX_TRACKS))
          n = MAX_TRACKS;
        else
          n = 32'(m_track_count);
        if (!m_seeded) begin
          m_offset = r.time_tenths % n;
          m_seeded = 1'b1;
        end
        // bias by 2n so a negative step never wraps below zero
        m_offset = (m_offset + 2 * n + 32'(r.track_step)
                    - (r.track_step[1] ? 32'd4 : 32'd0)) % n;
        if (!MUSIC_OOR) begin
          m_vol[SIW'(MUSIC_STREAM)]     = r.volume;
          m_pending[SIW'(MUSIC_STREAM)] = 8'(MUSIC_CODE);
          if (try_preempt(SIW'(MUSIC_STREAM), c))
            expected_cmds.push_back(c);
        end
      end
      OP_FINISH: expected_cmds.push_back(finish_and_walk());
      OP_RETRY:  expected_cmds.push_back(play_active());
      default: ;
    endcase
  endfunction

  function automatic void queue_req(logic [2:0] op, logic [3:0] idx, logic skip,
                                    logic [7:0] skip_eff, logic [7:0] loop_eff,
                                    logic [7:0] vol, logic [1:0] step,
                                    logic [31:0] now);
    snd_req_t r;
    r.opcode       = op;
    r.stream_index = idx;
    r.skip_flag    = skip;
    r.skip_effect  = skip_eff;
    r.loop_effect  = loop_eff;
    r.volume       = vol;
    r.track_step   = step;
    r.time_tenths  = now;
    pending_reqs.push_back(r);
    n_pushed++;
  endfunction

  function automatic logic [7:0] pick_effect();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return 8'(SILENCE_CODE);
    if (roll < 30) return 8'($urandom_range(255, NUM_EFFECTS));
    if (roll < 35) return 8'(MUSIC_CODE);
    return 8'($urandom_range(NUM_EFFECTS - 1, 1));
  endfunction

  function automatic void queue_random_req();
    int unsigned roll;
    logic [2:0]  op;
    logic [3:0]  idx;
    roll = $urandom_range(99);
    if (roll < 40)      op = OP_EFFECT;
    else if (roll < 50) op = OP_VOLUME;
    else if (roll < 65) op = OP_MUSIC;
    else if (roll < 90) op = OP_FINISH;
    else if (roll < 97) op = OP_RETRY;
    else                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    if ($urandom_range(99) < 90)
      idx = 4'($urandom_range(NUM_STREAMS - 1));
    else
      idx = 4'($urandom_range(15, NUM_STREAMS));
    queue_req(op, idx, $urandom_range(99) < 70, pick_effect(), pick_effect(),
              8'($urandom_range(255)), 2'($urandom_range(3)), $urandom);
  endfunction

  task automatic write_track_count(input logic [TRK_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    m_track_count  = value;
  endtask

  // Hold off until all requests are taken and commands are back, or time out
  task automatic drain_and_rest();
    int spins;
    while (n_accepted != n_pushed) @(posedge clk);
    spins = 0;
    while (expected_cmds.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_requests
    bit fired;
    if (!rst) begin
      fired = start && !busy;
      if (fired) begin
        predict_cmd(cur_req);
        n_accepted++;
      end
      if (!start || fired) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 29)) begin
          cur_req       = pending_reqs.pop_front();
          opcode       <= cur_req.opcode;
          stream_index <= cur_req.stream_index;
          skip_flag    <= cur_req.skip_flag;
          skip_effect  <= cur_req.skip_effect;
          loop_effect  <= cur_req.loop_effect;
          volume       <= cur_req.volume;
          track_step   <= cur_req.track_step;
          time_tenths  <= cur_req.time_tenths;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_commands
    snd_cmd_t want;
    if (!rst && result_valid) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("command with no transaction pending, action %0d",
                                  action));
      end else begin
        want = expected_cmds.pop_front();
        if (action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", action, want.action));
        if (active_index !== want.active_index)
          report_mismatch($sformatf("active_index %0d, want %0d",
                                    active_index, want.active_index));
        if (effect_code !== want.effect_code)
          report_mismatch($sformatf("effect_code %0d, want %0d",
                                    effect_code, want.effect_code));
        if (track_index !== want.track_index)
          report_mismatch($sformatf("track_index %0d, want %0d",
                                    track_index, want.track_index));
        if (out_volume !== want.out_volume)
          report_mismatch($sformatf("out_volume %0d, want %0d",
                                    out_volume, want.out_volume));
      end
    end
  end

  initial begin : stimulus
    logic [TRK_W-1:0] count;
    m_pending = '{default: 8'(SILENCE_CODE)};
    m_loop    = '{default: 8'(SILENCE_CODE)};
    m_vol     = '{default: 8'd0};
    if (BACKGROUND_STREAM < NUM_STREAMS)
      m_vol[SIW'(BACKGROUND_STREAM)] = 8'(BG_RESET_VOLUME);
    m_active      = '0;
    m_offset      = 0;
    m_seeded      = 1'b0;
    m_track_count = TRK_W'(1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_track_count(TRK_W'(5));

    // Directed: reset state, out-of-table streams, preemption and the walk
    queue_req(OP_RETRY,  0,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_VOLUME, 0,  0, 0,   0,   255, STEP_HOLD, 0);
    queue_req(OP_VOLUME, 3,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_VOLUME, 15, 0, 0,   0,   77,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 15, 1, 9,   9,   77,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 1,  0, 33,  5,   20,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 1,  1, 127, 5,   21,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 0,  1, 10,  10,  30,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 3,  1, 200, 0,   40,  STEP_HOLD, 0);
    queue_req(OP_EFFECT, 1,  1, 0,   0,   22,  STEP_HOLD, 0);
    queue_req(OP_FINISH, 0,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_MUSIC,  0,  0, 0,   0,   255, STEP_FWD,  32'hFFFF_FFFF);
    queue_req(OP_MUSIC,  0,  0, 0,   0,   128, STEP_BACK, 7);
    queue_req(OP_MUSIC,  0,  0, 0,   0,   1,   STEP_BACK2, 0);
    queue_req(OP_MUSIC,  0,  0, 0,   0,   0,   STEP_HOLD, 123);
    queue_req(OP_FINISH, 0,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_EFFECT, 0,  1, 0,   0,   8,   STEP_HOLD, 0);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      queue_req(3'(op), 0, 1, 50, 50, 50, STEP_FWD, 1);
    queue_req(OP_EFFECT, 2,  1, 1,   255, 90,  STEP_HOLD, 0);
    queue_req(OP_FINISH, 0,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_RETRY,  0,  0, 0,   0,   0,   STEP_HOLD, 0);
    queue_req(OP_EFFECT, 3,  1, 255, 128, 255, STEP_HOLD, 0);
    queue_req(OP_FINISH, 0,  0, 0,   0,   0,   STEP_HOLD, 0);
    drain_and_rest();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       count = '0;
        1:       count = TRK_W'(MAX_TRACKS);
        2:       count = '1;
        3:       count = TRK_W'(1);
        4:       count = TRK_W'(2);
        default: count = TRK_W'($urandom_range(MAX_TRACKS, 1));
      endcase
      write_track_count(count);
      no_gaps = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++)
        queue_random_req();
      drain_and_rest();
    end

    if (expected_cmds.size() != 0)
      report_mismatch($sformatf("%0d expected commands never arrived",
                                expected_cmds.size()));
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
